// File: hw/rtl/owbm_pkg.sv
package owbm_pkg;

    localparam int BitsPerTransfer = 8;

    localparam int CfgCount  = 8;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 10;
    localparam int CountW    = 10;
    localparam int ByteW     = 8;
    localparam int BitIdxW   = 3;
    localparam int InDataW   = 16;
    localparam int OutDataW  = 16;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_TICK  = 2'd0;
    localparam t_mode MODE_RESET = 2'd1;
    localparam t_mode MODE_WRITE = 2'd2;
    localparam t_mode MODE_READ  = 2'd3;

    localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_WRITE_SHORT   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_WRITE_LONG    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_READ_LOW      = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE   = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_READ_TAIL     = 3'd7;

    localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
    localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd80;
    localparam logic [9:0] RESET_TAIL_DEF    = 10'd400;
    localparam logic [3:0] WRITE_SHORT_DEF   = 4'd1;
    localparam logic [6:0] WRITE_LONG_DEF    = 7'd60;
    localparam logic [3:0] READ_LOW_DEF      = 4'd2;
    localparam logic [5:0] READ_SAMPLE_DEF   = 6'd10;
    localparam logic [6:0] READ_TAIL_DEF     = 7'd50;

    // phase length, a zero register counts as one tick
    function automatic logic [CountW-1:0] count_load(input logic [CountW-1:0] ticks);
        count_load = (ticks == '0) ? CountW'(1) : ticks;
    endfunction

endpackage

// File: hw/rtl/one_wire_bus_master_core.sv
// 1-Wire bus master bit timer. Each request on the input stream is one microsecond tick
// carrying the sampled bus level and optionally a command (reset with presence detect,
// byte write, byte read, bits least significant first); each tick yields exactly one
// result with the drive level, busy, a done pulse, the presence flag and the last byte
// read. The command sequencer updates its state and the result register in the cycle
// the request is accepted, so one request per cycle is taken while the output keeps up.
// Slot timing comes from the eight timing registers; the user must write them over the
// configuration channel only while no command is running; it is not enforced.
module one_wire_bus_master_core
    import owbm_pkg::*;
#(
    parameter int BITS_PER_TRANSFER = BitsPerTransfer
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [7:0] tx_byte, [8] line_in, [15:9] zero
    input  logic [InDataW-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence_found,
    // [11:4] read_byte, [15:12] zero
    output logic [OutDataW-1:0] m_axis_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_WR_LOW,
        PH_WR_REL,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_TAIL
    } t_phase;

    localparam logic [BitIdxW-1:0] LastBit = BitIdxW'(BITS_PER_TRANSFER - 1);

    logic [9:0] r_reset_low;
    logic [7:0] r_presence_wait;
    logic [9:0] r_reset_tail;
    logic [3:0] r_write_short;
    logic [6:0] r_write_long;
    logic [3:0] r_read_low;
    logic [5:0] r_read_sample;
    logic [6:0] r_read_tail;

    t_phase              r_phase, n_phase;
    logic [CountW-1:0]   r_countdown, n_countdown;
    logic [BitIdxW-1:0]  r_bit_index, n_bit_index;
    logic [ByteW-1:0]    r_shift_byte, n_shift_byte;
    t_mode               r_command_kind, n_command_kind;
    logic                r_presence, n_presence;
    logic [ByteW-1:0]    r_read_result, n_read_result;
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data, n_out_data;

    logic                in_accept;
    t_mode               in_mode;
    logic [ByteW-1:0]    in_tx;
    logic                in_line;
    logic [CountW-1:0]   wr_short_ticks;
    logic [CountW-1:0]   wr_long_ticks;

    assign in_mode = s_axis_tuser;
    assign in_tx   = s_axis_tdata[ByteW-1:0];
    assign in_line = s_axis_tdata[ByteW];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign wr_short_ticks = CountW'(r_write_short);
    assign wr_long_ticks  = CountW'(r_write_long);

    always_comb begin
        logic drive;
        logic busy;
        logic done;
        logic [CountW-1:0] cnt;

        n_phase        = r_phase;
        n_countdown    = r_countdown;
        n_bit_index    = r_bit_index;
        n_shift_byte   = r_shift_byte;
        n_command_kind = r_command_kind;
        n_presence     = r_presence;
        n_read_result  = r_read_result;
        drive          = 1'b0;
        busy           = 1'b0;
        done           = 1'b0;
        cnt            = '0;

        // command start
        if (r_phase == PH_IDLE && in_mode != MODE_TICK) begin
            n_command_kind = in_mode;
            n_bit_index    = '0;
            case (in_mode)
                MODE_RESET: begin
                    n_presence  = 1'b0;
                    n_phase     = PH_RST_LOW;
                    n_countdown = count_load(r_reset_low);
                end
                MODE_WRITE: begin
                    n_shift_byte = in_tx;
                    n_phase      = PH_WR_LOW;
                    n_countdown  = count_load(in_tx[0] ? wr_short_ticks : wr_long_ticks);
                end
                default: begin
                    n_shift_byte = '0;
                    n_phase      = PH_RD_LOW;
                    n_countdown  = count_load(CountW'(r_read_low));
                end
            endcase
        end

        if (n_phase != PH_IDLE) begin
            busy  = 1'b1;
            drive = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW)
                 || (n_phase == PH_RD_LOW);
            cnt         = n_countdown - CountW'(1);
            n_countdown = cnt;
            if (cnt == '0) begin
                case (n_phase)
                    PH_RST_LOW: begin
                        n_phase     = PH_RST_WAIT;
                        n_countdown = count_load(CountW'(r_presence_wait));
                    end
                    PH_RST_WAIT: begin
                        n_presence  = !in_line;
                        n_phase     = PH_TAIL;
                        n_countdown = count_load(r_reset_tail);
                    end
                    PH_WR_LOW: begin
                        n_phase     = PH_WR_REL;
                        n_countdown = count_load(n_shift_byte[0] ? wr_long_ticks
                                                                 : wr_short_ticks);
                    end
                    PH_WR_REL: begin
                        if (n_bit_index >= LastBit) begin
                            done    = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_shift_byte = {1'b0, n_shift_byte[ByteW-1:1]};
                            n_bit_index  = n_bit_index + BitIdxW'(1);
                            n_phase      = PH_WR_LOW;
                            n_countdown  = count_load(n_shift_byte[0] ? wr_short_ticks
                                                                      : wr_long_ticks);
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase     = PH_RD_WAIT;
                        n_countdown = count_load(CountW'(r_read_sample));
                    end
                    PH_RD_WAIT: begin
                        if (in_line) begin
                            n_shift_byte = n_shift_byte | (ByteW'(1) << n_bit_index);
                        end
                        n_phase     = PH_TAIL;
                        n_countdown = count_load(CountW'(r_read_tail));
                    end
                    PH_TAIL: begin
                        if (n_command_kind == MODE_RESET) begin
                            done    = 1'b1;
                            n_phase = PH_IDLE;
                        end else if (n_bit_index >= LastBit) begin
                            n_read_result = n_shift_byte;
                            done          = 1'b1;
                            n_phase       = PH_IDLE;
                        end else begin
                            n_bit_index = n_bit_index + BitIdxW'(1);
                            n_phase     = PH_RD_LOW;
                            n_countdown = count_load(CountW'(r_read_low));
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        n_out_data = {4'b0, n_read_result, n_presence, done, busy, drive};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low     <= RESET_LOW_DEF;
            r_presence_wait <= PRESENCE_WAIT_DEF;
            r_reset_tail    <= RESET_TAIL_DEF;
            r_write_short   <= WRITE_SHORT_DEF;
            r_write_long    <= WRITE_LONG_DEF;
            r_read_low      <= READ_LOW_DEF;
            r_read_sample   <= READ_SAMPLE_DEF;
            r_read_tail     <= READ_TAIL_DEF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RESET_LOW:     r_reset_low     <= i_cfg_data;
                CFG_PRESENCE_WAIT: r_presence_wait <= i_cfg_data[7:0];
                CFG_RESET_TAIL:    r_reset_tail    <= i_cfg_data;
                CFG_WRITE_SHORT:   r_write_short   <= i_cfg_data[3:0];
                CFG_WRITE_LONG:    r_write_long    <= i_cfg_data[6:0];
                CFG_READ_LOW:      r_read_low      <= i_cfg_data[3:0];
                CFG_READ_SAMPLE:   r_read_sample   <= i_cfg_data[5:0];
                CFG_READ_TAIL:     r_read_tail     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_countdown    <= '0;
            r_bit_index    <= '0;
            r_shift_byte   <= '0;
            r_command_kind <= MODE_TICK;
            r_presence     <= 1'b0;
            r_read_result  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase        <= n_phase;
                r_countdown    <= n_countdown;
                r_bit_index    <= n_bit_index;
                r_shift_byte   <= n_shift_byte;
                r_command_kind <= n_command_kind;
                r_presence     <= n_presence;
                r_read_result  <= n_read_result;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// File: tb/sv/one_wire_bus_master_core_tb.sv
`timescale 1ns / 100ps

module one_wire_bus_master_core_tb;
    import owbm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RST_LOW,
        ST_RST_WAIT,
        ST_WR_LOW,
        ST_WR_REL,
        ST_RD_LOW,
        ST_RD_WAIT,
        ST_TAIL
    } t_slot_state;

    typedef struct packed {
        logic [ByteW-1:0] read_byte;
        logic             presence;
        logic             done;
        logic             busy;
        logic             drive_low;
    } t_bus_status;

    typedef struct packed {
        t_mode            mode;
        logic [ByteW-1:0] tx_byte;
        logic             line_in;
        logic             typed;
        t_bus_status      status;
    } t_tick_row;

    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 300;
    localparam int PhaseTicks = 130;
    localparam int DirectedRows = 9;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    // timing registers as the predictor sees them, and the next set to program
    logic [CountW-1:0] timing      [CfgCount];
    logic [CountW-1:0] timing_plan [CfgCount];

    t_slot_state       slot_state;
    logic [CountW-1:0] slot_left;
    logic [BitIdxW-1:0] bit_pos;
    logic [ByteW-1:0]  shift_reg;
    t_mode             active_cmd;
    logic              presence_seen;
    logic [ByteW-1:0]  last_read;

    t_bus_status status_q[$];
    t_bus_status got_status;
    t_bus_status want_status;
    t_bus_status pred_status;

    int errors;
    int cycle_count;
    int tx_gap_pct;
    int rx_gap_pct;
    bit hold_req;
    bit hold_served;
    logic        row_typed;
    t_bus_status row_status;

    // zero timing everywhere: every phase is one tick
    t_tick_row directed_rows [DirectedRows] = '{
        '{MODE_TICK,  8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{MODE_RESET, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{MODE_WRITE, 8'h5a, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{MODE_READ,  8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{MODE_TICK,  8'hff, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{MODE_RESET, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{MODE_TICK,  8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{MODE_TICK,  8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{MODE_WRITE, 8'hff, 1'b1, 1'b0, '0}
    };

    one_wire_bus_master_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CountW-1:0] timing_mask(logic [CfgIdxW-1:0] idx);
        case (idx)
            CFG_RESET_LOW, CFG_RESET_TAIL: return 10'h3ff;
            CFG_PRESENCE_WAIT:             return 10'h0ff;
            CFG_WRITE_SHORT, CFG_READ_LOW: return 10'h00f;
            CFG_WRITE_LONG, CFG_READ_TAIL: return 10'h07f;
            CFG_READ_SAMPLE:               return 10'h03f;
            default:                       return 10'h000;
        endcase
    endfunction

    function automatic void enter_slot(t_slot_state s, logic [CountW-1:0] ticks);
        slot_state = s;
        slot_left  = (ticks == 0) ? CountW'(1) : ticks;
    endfunction

    // low time of a write slot for the given bit
    function automatic logic [CountW-1:0] write_low_len(logic b);
        return b ? timing[CFG_WRITE_SHORT] : timing[CFG_WRITE_LONG];
    endfunction

    function automatic t_bus_status bus_tick(t_mode mode, logic [ByteW-1:0] tx, logic line);
        t_bus_status st;
        st = '0;
        if (slot_state == ST_IDLE && mode != MODE_TICK) begin
            active_cmd = mode;
            bit_pos    = '0;
            case (mode)
                MODE_RESET: begin
                    presence_seen = 1'b0;
                    enter_slot(ST_RST_LOW, timing[CFG_RESET_LOW]);
                end
                MODE_WRITE: begin
                    shift_reg = tx;
                    enter_slot(ST_WR_LOW, write_low_len(tx[0]));
                end
                default: begin
                    shift_reg = '0;
                    enter_slot(ST_RD_LOW, timing[CFG_READ_LOW]);
                end
            endcase
        end
        if (slot_state != ST_IDLE) begin
            st.busy      = 1'b1;
            st.drive_low = (slot_state == ST_RST_LOW) || (slot_state == ST_WR_LOW)
                        || (slot_state == ST_RD_LOW);
            slot_left = slot_left - 1'b1;
            if (slot_left == 0) begin
                case (slot_state)
                    ST_RST_LOW: enter_slot(ST_RST_WAIT, timing[CFG_PRESENCE_WAIT]);
                    ST_RST_WAIT: begin
                        presence_seen = ~line;
                        enter_slot(ST_TAIL, timing[CFG_RESET_TAIL]);
                    end
                    ST_WR_LOW: enter_slot(ST_WR_REL, shift_reg[0] ? timing[CFG_WRITE_LONG]
                                                                : timing[CFG_WRITE_SHORT]);
                    ST_WR_REL: begin
                        if (int'(bit_pos) >= BitsPerTransfer - 1) begin
                            st.done    = 1'b1;
                            slot_state = ST_IDLE;
                        end else begin
                            shift_reg = shift_reg >> 1;
                            bit_pos   = bit_pos + 1'b1;
                            enter_slot(ST_WR_LOW, write_low_len(shift_reg[0]));
                        end
                    end
                    ST_RD_LOW: enter_slot(ST_RD_WAIT, timing[CFG_READ_SAMPLE]);
                    ST_RD_WAIT: begin
                        if (line) shift_reg[bit_pos] = 1'b1;
                        enter_slot(ST_TAIL, timing[CFG_READ_TAIL]);
                    end
                    default: begin
                        if (active_cmd == MODE_RESET) begin
                            st.done    = 1'b1;
                            slot_state = ST_IDLE;
                        end else if (int'(bit_pos) >= BitsPerTransfer - 1) begin
                            last_read  = shift_reg;
                            st.done    = 1'b1;
                            slot_state = ST_IDLE;
                        end else begin
                            bit_pos = bit_pos + 1'b1;
                            enter_slot(ST_RD_LOW, timing[CFG_READ_LOW]);
                        end
                    end
                endcase
            end
        end
        st.presence  = presence_seen;
        st.read_byte = last_read;
        return st;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // results are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_status = t_bus_status'(m_axis_tdata[11:0]);
                if (status_q.size() == 0) begin
                    $error("result %h with nothing expected", m_axis_tdata);
                    errors++;
                end else begin
                    want_status = status_q.pop_front();
                    check_field("drive_low", want_status.drive_low, got_status.drive_low);
                    check_field("busy_res", want_status.busy, got_status.busy);
                    check_field("done_res", want_status.done, got_status.done);
                    check_field("presence_found", want_status.presence, got_status.presence);
                    check_field("read_byte", want_status.read_byte, got_status.read_byte);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred_status = bus_tick(t_mode'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8]);
                status_q.push_back(row_typed ? row_status : pred_status);
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
            end
            m_axis_tready <= (rx_gap_pct == 0) || ($urandom_range(99) >= rx_gap_pct);
        end
    end

    task automatic send_tick(t_mode mode, logic [ByteW-1:0] tx, logic line, logic typed,
                             t_bus_status st);
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, line, tx};
        s_axis_tuser  <= mode;
        row_typed  = typed;
        row_status = st;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // tick until the command is over, then drain every pending result
    task automatic settle();
        while (slot_state != ST_IDLE)
            send_tick(t_mode'($urandom_range(3)), 8'($urandom), 1'($urandom), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_timing();
        for (int i = 0; i < CfgCount; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CfgIdxW'(i);
            i_cfg_data  <= timing_plan[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            timing[i] = timing_plan[i] & timing_mask(CfgIdxW'(i));
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic plan_short_timing();
        for (int i = 0; i < CfgCount; i++)
            timing_plan[i] = CountW'($urandom_range(3));
    endtask

    // mostly whole commands, with ignored starts sprinkled in while busy
    task automatic run_random(int n);
        t_mode m;
        for (int k = 0; k < n; k++) begin
            if (slot_state == ST_IDLE)
                m = ($urandom_range(99) < 85) ? t_mode'($urandom_range(3, 1)) : MODE_TICK;
            else
                m = ($urandom_range(99) < 90) ? MODE_TICK : t_mode'($urandom_range(3));
            send_tick(m, 8'($urandom), 1'($urandom), 1'b0, '0);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_TICK;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_RESET_LOW;
        i_cfg_data    = '0;
        row_typed     = 1'b0;
        row_status    = '0;
        errors        = 0;
        cycle_count   = 0;
        hold_req      = 1'b0;
        hold_served   = 1'b0;
        tx_gap_pct    = 13;
        rx_gap_pct    = 64;
        timing[CFG_RESET_LOW]     = RESET_LOW_DEF;
        timing[CFG_PRESENCE_WAIT] = CountW'(PRESENCE_WAIT_DEF);
        timing[CFG_RESET_TAIL]    = RESET_TAIL_DEF;
        timing[CFG_WRITE_SHORT]   = CountW'(WRITE_SHORT_DEF);
        timing[CFG_WRITE_LONG]    = CountW'(WRITE_LONG_DEF);
        timing[CFG_READ_LOW]      = CountW'(READ_LOW_DEF);
        timing[CFG_READ_SAMPLE]   = CountW'(READ_SAMPLE_DEF);
        timing[CFG_READ_TAIL]     = CountW'(READ_TAIL_DEF);
        slot_state    = ST_IDLE;
        slot_left     = '0;
        bit_pos       = '0;
        shift_reg     = '0;
        active_cmd    = MODE_TICK;
        presence_seen = 1'b0;
        last_read     = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero registers count as one tick
        for (int i = 0; i < CfgCount; i++) timing_plan[i] = '0;
        program_timing();
        foreach (directed_rows[r])
            send_tick(directed_rows[r].mode, directed_rows[r].tx_byte,
                      directed_rows[r].line_in, directed_rows[r].typed,
                      directed_rows[r].status);
        settle();

        plan_short_timing();
        program_timing();
        run_random(PhaseTicks);
        settle();

        tx_gap_pct = 64;
        rx_gap_pct = 13;
        plan_short_timing();
        program_timing();
        run_random(PhaseTicks);
        settle();

        tx_gap_pct = 0;
        rx_gap_pct = 0;
        hold_req   = 1'b1;
        plan_short_timing();
        program_timing();
        run_random(PhaseTicks);
        settle();

        // bits above each register width are dropped
        for (int i = 0; i < CfgCount; i++)
            timing_plan[i] = ~timing_mask(CfgIdxW'(i)) | CountW'($urandom_range(3));
        program_timing();
        send_tick(MODE_RESET, 8'($urandom), 1'($urandom), 1'b0, '0);
        settle();
        send_tick(MODE_WRITE, 8'($urandom), 1'($urandom), 1'b0, '0);
        settle();
        send_tick(MODE_READ, 8'($urandom), 1'($urandom), 1'b0, '0);
        settle();

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/owbm_pkg.sv
hw/rtl/one_wire_bus_master_core.sv
tb/sv/one_wire_bus_master_core_tb.sv
